>>> rtl/core/lr_pkg.sv
`timescale 1ns / 1ps

package lr_pkg;

  localparam int MAX_DIM = 64;
  localparam int COORD_W = 6;
  localparam int COLOR_W = 8;
  localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(MAX_DIM - 1);

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] pixel_red;
    logic [COLOR_W-1:0] pixel_green;
    logic [COLOR_W-1:0] pixel_blue;
    logic               last_pixel;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic step;
  } lr_cmd_t;

  typedef struct packed {
    logic last;
  } lr_status_t;

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
    clamp_coord = (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

endpackage

>>> rtl/core/lr_datapath.sv
`timescale 1ns / 1ps

module lr_datapath import lr_pkg::*; (
  input  logic       clk,
  input  in_item_t   in_data,
  input  lr_cmd_t    cmd,
  output lr_status_t status,
  output out_item_t  out_data
);

  // line registers
  logic [COORD_W-1:0]   maj_r, maj_nxt;
  logic [COORD_W-1:0]   end_r, end_nxt;
  logic [COORD_W-1:0]   span_r, span_nxt;
  logic [COORD_W-1:0]   minor_r, minor_nxt;
  logic [COORD_W-1:0]   rem_r, rem_nxt;
  logic signed [COORD_W:0] delta_r, delta_nxt;
  logic                 steep_r, steep_nxt;
  logic [3*COLOR_W-1:0] color_r, color_nxt;

  // setup terms
  logic [COORD_W-1:0] xa, ya, xb, yb, adx, ady;
  logic [COORD_W-1:0] m0, n0, m1, n1;
  logic               steep;

  // stepping terms
  logic signed [COORD_W+2:0] rem_sum;
  logic signed [COORD_W+2:0] span_ext;

  always_comb begin
    xa = clamp_coord(in_data.start_x);
    ya = clamp_coord(in_data.start_y);
    xb = clamp_coord(in_data.end_x);
    yb = clamp_coord(in_data.end_y);
    adx = (xa > xb) ? (xa - xb) : (xb - xa);
    ady = (ya > yb) ? (ya - yb) : (yb - ya);
    steep = adx < ady;
    if (steep) begin
      m0 = ya; n0 = xa; m1 = yb; n1 = xb;
    end else begin
      m0 = xa; n0 = ya; m1 = xb; n1 = yb;
    end
    // order endpoints so the major coordinate rises
    if (m0 > m1) begin
      {m0, m1} = {m1, m0};
      {n0, n1} = {n1, n0};
    end
  end

  // remainder stays in [0, span); |delta| <= span so one correction per step
  always_comb begin
    span_ext = {3'b000, span_r};
    rem_sum  = $signed({3'b000, rem_r}) + {{2{delta_r[COORD_W]}}, delta_r};

    maj_nxt   = maj_r;
    end_nxt   = end_r;
    span_nxt  = span_r;
    minor_nxt = minor_r;
    rem_nxt   = rem_r;
    delta_nxt = delta_r;
    steep_nxt = steep_r;
    color_nxt = color_r;

    if (cmd.load) begin
      maj_nxt   = m0;
      end_nxt   = m1;
      span_nxt  = m1 - m0;
      minor_nxt = n0;
      rem_nxt   = '0;
      delta_nxt = $signed({1'b0, n1}) - $signed({1'b0, n0});
      steep_nxt = steep;
      color_nxt = {in_data.red, in_data.green, in_data.blue};
    end else if (cmd.step) begin
      maj_nxt = maj_r + 1'b1;
      if (rem_sum < 0) begin
        rem_nxt   = COORD_W'(rem_sum + span_ext);
        minor_nxt = minor_r - 1'b1;
      end else if (rem_sum >= span_ext && span_r != '0) begin
        rem_nxt   = COORD_W'(rem_sum - span_ext);
        minor_nxt = minor_r + 1'b1;
      end else begin
        rem_nxt = COORD_W'(rem_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    maj_r   <= maj_nxt;
    end_r   <= end_nxt;
    span_r  <= span_nxt;
    minor_r <= minor_nxt;
    rem_r   <= rem_nxt;
    delta_r <= delta_nxt;
    steep_r <= steep_nxt;
    color_r <= color_nxt;
  end

  assign status.last = (maj_r == end_r);

  always_comb begin
    out_data.pixel_x     = steep_r ? minor_r : maj_r;
    out_data.pixel_y     = steep_r ? maj_r : minor_r;
    out_data.pixel_red   = color_r[3*COLOR_W-1:2*COLOR_W];
    out_data.pixel_green = color_r[2*COLOR_W-1:COLOR_W];
    out_data.pixel_blue  = color_r[COLOR_W-1:0];
    out_data.last_pixel  = status.last;
  end

endmodule

>>> rtl/core/lr_ctrl.sv
`timescale 1ns / 1ps

module lr_ctrl import lr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  lr_status_t status,
  output lr_cmd_t    cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    in_ready_nxt  = in_ready_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load      = 1'b1;
          state_nxt     = ST_EMIT;
          in_ready_nxt  = 1'b0;
          out_valid_nxt = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          if (status.last) begin
            state_nxt     = ST_IDLE;
            in_ready_nxt  = 1'b1;
            out_valid_nxt = 1'b0;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: begin
        state_nxt     = ST_IDLE;
        in_ready_nxt  = 1'b1;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule

>>> rtl/core/line_rasterizer_top.sv
`timescale 1ns / 1ps

// Line rasterizer: takes one line beat (two endpoints and a colour) and emits
// one pixel beat per unit step along the major axis, lowest major coordinate
// first, with last_pixel set on the final pixel. A line of major span n gives
// n+1 pixels (a zero-length line gives its single point). The block first
// loads and sets up the line, then gives one pixel per cycle from an exact
// error-accumulator stepper, as long as the output is not stalled.
// A new line is taken only after the last pixel of the previous one has gone.
module line_rasterizer_top import lr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  lr_cmd_t    cmd;
  lr_status_t status;

  lr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lr_datapath u_datapath (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  // one line at a time
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while pixels pending");

  a_accept_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted line produced no pixel");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last_pixel) |=> (in_ready && !out_valid))
    else $error("block not idle after last pixel");

  a_step_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last_pixel) |=> out_valid)
    else $error("line ended without last pixel");
`endif

endmodule
